>>> hdl/tpsm_pkg.sv
// ----------------------------------------------------------------------------
// tpsm_pkg: shared types and constants for the two-phase stiffness mat-vec
// Item layout, operation and phase codes, and data widths used by the
// column cells, the output stage and the top level.
// ----------------------------------------------------------------------------
package tpsm_pkg;

	localparam int NUM_X   = 6;
	localparam int DATA_W  = 32;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int ACC_W   = PROD_W + 3;
	localparam int IDX_W   = 3;
	localparam int IN_DATA_W  = 232;
	localparam int OUT_DATA_W = NUM_X * DATA_W;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_APPLY = 1'b1;

	localparam logic PHASE_MATRIX    = 1'b0;
	localparam logic PHASE_INCLUSION = 1'b1;

	typedef struct packed {
		logic                              op;
		logic                              phase;
		logic [IDX_W-1:0]                  row;
		logic [IDX_W-1:0]                  col;
		logic [DATA_W-1:0]                 coef;
		logic [NUM_X-1:0][DATA_W-1:0]      x;
		logic [NUM_X-1:0][ACC_W-1:0]       acc;
	} tpsm_item_t;

endpackage

>>> hdl/two_phase_stiffness_matvec_top.sv
// ----------------------------------------------------------------------------
// two_phase_stiffness_matvec_top: two-phase stiffness matrix-vector unit
// Each accepted apply beat passes two register stages in every column cell
// and then the output register before it leaves as a result beat.
// Throughput: one beat per cycle, loads and applies alike, while the output is not held off.
// Reset clears both coefficient matrices to zero and sets the count to six.
// ----------------------------------------------------------------------------
module two_phase_stiffness_matvec_top
	import tpsm_pkg::*;
#(
	parameter int MAX_COMPONENTS = 6,
	parameter int FRAC_BITS      = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [IDX_W-1:0]      cfg_wr_data,   // components
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// row, col, coefficient, x_0, x_1, x_2, x_3, x_4, x_5, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,       // operation, phase
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,       // y_0, y_1, y_2, y_3, y_4, y_5
	output logic                  m_tuser        // saturated
);

	localparam int XBASE = 2 * IDX_W + DATA_W;

	logic [IDX_W-1:0] components_q;
	logic [IDX_W-1:0] count;
	logic             chain_valid [MAX_COMPONENTS+1];
	logic             chain_ready [MAX_COMPONENTS+1];
	tpsm_item_t       chain_item  [MAX_COMPONENTS+1];
	tpsm_item_t       in_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			components_q <= IDX_W'(6);
		end else if (cfg_wr_en) begin
			components_q <= cfg_wr_data;
		end
	end

	assign count = (components_q > IDX_W'(MAX_COMPONENTS)) ? IDX_W'(MAX_COMPONENTS)
	                                                       : components_q;

	always_comb begin
		in_item       = '0;
		in_item.op    = s_tuser[0];
		in_item.phase = s_tuser[1];
		in_item.row   = s_tdata[IDX_W-1:0];
		in_item.col   = s_tdata[2*IDX_W-1:IDX_W];
		in_item.coef  = s_tdata[2*IDX_W +: DATA_W];
		for (int k = 0; k < NUM_X; k++) begin
			in_item.x[k] = s_tdata[XBASE + k*DATA_W +: DATA_W];
		end
	end

	assign chain_valid[0] = s_tvalid;
	assign chain_item[0]  = in_item;
	assign s_tready       = chain_ready[0];

	for (genvar c = 0; c < MAX_COMPONENTS; c++) begin : g_cell
		tpsm_cell #(
			.COL            (c),
			.MAX_COMPONENTS (MAX_COMPONENTS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.count     (count),
			.in_valid  (chain_valid[c]),
			.in_item   (chain_item[c]),
			.in_ready  (chain_ready[c]),
			.out_valid (chain_valid[c+1]),
			.out_item  (chain_item[c+1]),
			.out_ready (chain_ready[c+1])
		);
	end

	tpsm_out #(
		.FRAC_BITS (FRAC_BITS)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[MAX_COMPONENTS]),
		.in_item  (chain_item[MAX_COMPONENTS]),
		.in_ready (chain_ready[MAX_COMPONENTS]),
		.m_valid  (m_tvalid),
		.m_data   (m_tdata),
		.m_sat    (m_tuser),
		.m_ready  (m_tready)
	);

	function automatic logic at_bound(input logic [DATA_W-1:0] v);
		return v == {1'b1, {(DATA_W-1){1'b0}}} || v == {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			at_bound(m_tdata[0*DATA_W +: DATA_W]) || at_bound(m_tdata[1*DATA_W +: DATA_W]) ||
			at_bound(m_tdata[2*DATA_W +: DATA_W]) || at_bound(m_tdata[3*DATA_W +: DATA_W]) ||
			at_bound(m_tdata[4*DATA_W +: DATA_W]) || at_bound(m_tdata[5*DATA_W +: DATA_W]))
		else $error("Saturation flag set with no component at a limit.");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && count == '0 |-> m_tdata == '0 && !m_tuser)
		else $error("Nonzero result with a component count of zero.");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && count == IDX_W'(1) |-> m_tdata[OUT_DATA_W-1:DATA_W] == '0)
		else $error("Unused result components are not zero.");

endmodule

>>> hdl/tpsm_cell.sv
// ----------------------------------------------------------------------------
// tpsm_cell: one column cell of the multiply-accumulate chain
// Holds one column of both coefficient matrices, multiplies its vector
// component by that column and adds the products to the running row sums.
// ----------------------------------------------------------------------------
module tpsm_cell
	import tpsm_pkg::*;
#(
	parameter int COL            = 0,
	parameter int MAX_COMPONENTS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] count,
	input  logic             in_valid,
	input  tpsm_item_t       in_item,
	output logic             in_ready,
	output logic             out_valid,
	output tpsm_item_t       out_item,
	input  logic             out_ready
);

	logic [DATA_W-1:0]        incl_q [MAX_COMPONENTS];
	logic [DATA_W-1:0]        mat_q  [MAX_COMPONENTS];
	logic                     va_q;
	logic                     vb_q;
	tpsm_item_t               item_s1;
	tpsm_item_t               item_s2;
	tpsm_item_t               item_c;
	logic signed [PROD_W-1:0] prod_s1 [MAX_COMPONENTS];
	logic signed [PROD_W-1:0] prod_c  [MAX_COMPONENTS];
	logic                     move_a;
	logic                     move_b;
	logic                     take;

	assign move_b    = !vb_q || out_ready;
	assign move_a    = !va_q || move_b;
	assign in_ready  = move_a;
	assign take      = in_valid && move_a;
	assign out_valid = vb_q;
	assign out_item  = item_s2;

	always_comb begin
		logic signed [DATA_W-1:0] coef_v;
		logic signed [DATA_W-1:0] x_v;
		x_v = $signed(in_item.x[COL]);
		for (int k = 0; k < MAX_COMPONENTS; k++) begin
			coef_v = (in_item.phase == PHASE_INCLUSION) ? $signed(incl_q[k]) : $signed(mat_q[k]);
			if (in_item.op == OP_APPLY && IDX_W'(COL) < count && IDX_W'(k) < count) begin
				prod_c[k] = coef_v * x_v;
			end else begin
				prod_c[k] = '0;
			end
		end
	end

	always_comb begin
		item_c = item_s1;
		for (int k = 0; k < MAX_COMPONENTS; k++) begin
			item_c.acc[k] = item_s1.acc[k]
				+ {{(ACC_W-PROD_W){prod_s1[k][PROD_W-1]}}, prod_s1[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_COMPONENTS; k++) begin
				incl_q[k] <= '0;
				mat_q[k]  <= '0;
			end
		end else if (take && in_item.op == OP_LOAD && in_item.col == IDX_W'(COL)) begin
			for (int k = 0; k < MAX_COMPONENTS; k++) begin
				if (in_item.row == IDX_W'(k)) begin
					if (in_item.phase == PHASE_INCLUSION) begin
						incl_q[k] <= in_item.coef;
					end else begin
						mat_q[k] <= in_item.coef;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= 1'b0;
			vb_q <= 1'b0;
		end else begin
			if (move_a) begin
				va_q <= in_valid;
			end
			if (move_b) begin
				vb_q <= va_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
			for (int k = 0; k < MAX_COMPONENTS; k++) begin
				prod_s1[k] <= prod_c[k];
			end
		end
		if (move_b && va_q) begin
			item_s2 <= item_c;
		end
	end

endmodule

>>> hdl/tpsm_out.sv
// ----------------------------------------------------------------------------
// tpsm_out: scaling, saturation and output register
// Shifts each row sum down by the fraction width, clips it to 32 bits and
// holds the result beat until the consumer takes it. Load items are dropped.
// ----------------------------------------------------------------------------
module tpsm_out
	import tpsm_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  tpsm_item_t            in_item,
	output logic                  in_ready,
	output logic                  m_valid,
	output logic [OUT_DATA_W-1:0] m_data,
	output logic                  m_sat,
	input  logic                  m_ready
);

	logic                  valid_q;
	logic [OUT_DATA_W-1:0] data_q;
	logic                  sat_q;
	logic [OUT_DATA_W-1:0] data_c;
	logic                  sat_c;

	assign in_ready = !valid_q || m_ready;
	assign m_valid  = valid_q;
	assign m_data   = data_q;
	assign m_sat    = sat_q;

	always_comb begin
		logic signed [ACC_W-1:0] sh_v;
		logic                    all1;
		logic                    all0;
		sat_c  = 1'b0;
		data_c = '0;
		for (int k = 0; k < NUM_X; k++) begin
			sh_v = $signed(in_item.acc[k]) >>> FRAC_BITS;
			all1 = &sh_v[ACC_W-1:DATA_W-1];
			all0 = ~|sh_v[ACC_W-1:DATA_W-1];
			if (all1 || all0) begin
				data_c[k*DATA_W +: DATA_W] = sh_v[DATA_W-1:0];
			end else begin
				sat_c = 1'b1;
				data_c[k*DATA_W +: DATA_W] = sh_v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
				                                           : {1'b0, {(DATA_W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid && in_item.op == OP_APPLY;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid && in_item.op == OP_APPLY) begin
			data_q <= data_c;
			sat_q  <= sat_c;
		end
	end

endmodule

>>> dv/two_phase_stiffness_matvec_checker.sv
// ----------------------------------------------------------------------------
// two_phase_stiffness_matvec_checker: scoreboard for the stiffness mat-vec unit
// Watches the configuration port and both streams, keeps its own copy of the
// two coefficient matrices and the component count, predicts the stress vector
// and saturation flag of every accepted apply beat, and compares each result
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_phase_stiffness_matvec_checker
	import tpsm_pkg::*;
#(
	parameter int MAX_COMPONENTS = 6,
	parameter int FRAC_BITS      = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [IDX_W-1:0]      cfg_wr_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tuser,
	output int                    mismatch_count,
	output int                    outstanding,
	output int                    results_checked
);

	localparam int ROW_LSB  = 0;
	localparam int COL_LSB  = ROW_LSB + IDX_W;
	localparam int COEF_LSB = COL_LSB + IDX_W;
	localparam int X_LSB    = COEF_LSB + DATA_W;
	localparam int DEPTH    = MAX_COMPONENTS * MAX_COMPONENTS;
	localparam int PRINT_CAP = 30;

	localparam logic signed [71:0] SAT_HI = 72'sh7FFF_FFFF;
	localparam logic signed [71:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic [NUM_X-1:0][DATA_W-1:0] y;
		logic                         sat;
	} stress_t;

	logic [DATA_W-1:0] inclusion_stiffness [DEPTH];
	logic [DATA_W-1:0] matrix_stiffness    [DEPTH];
	logic [IDX_W-1:0]  component_count;
	stress_t           expected_stress_q [$];

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("MISMATCH at %0t ns: %s", $time, what);
		end
	endtask

	function automatic stress_t compute_stress(input logic phase,
			input logic [NUM_X-1:0][DATA_W-1:0] strain);
		stress_t           r;
		logic signed [71:0] acc;
		logic signed [71:0] quo;
		logic [DATA_W-1:0]  c;
		int                 n;
		r = '0;
		n = (component_count > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(component_count);
		for (int k = 0; k < NUM_X; k++) begin
			if (k < n) begin
				acc = '0;
				for (int l = 0; l < n; l++) begin
					c = (phase == PHASE_INCLUSION) ? inclusion_stiffness[k*MAX_COMPONENTS+l]
						: matrix_stiffness[k*MAX_COMPONENTS+l];
					acc = acc + $signed(c) * $signed(strain[l]);
				end
				quo = acc >>> FRAC_BITS;
				if (quo > SAT_HI) begin
					r.y[k] = SAT_HI[DATA_W-1:0];
					r.sat  = 1'b1;
				end else if (quo < SAT_LO) begin
					r.y[k] = SAT_LO[DATA_W-1:0];
					r.sat  = 1'b1;
				end else begin
					r.y[k] = quo[DATA_W-1:0];
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stress_t                      got;
		stress_t                      want;
		logic [IDX_W-1:0]             row;
		logic [IDX_W-1:0]             col;
		logic [DATA_W-1:0]            coef;
		logic [NUM_X-1:0][DATA_W-1:0] strain;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				inclusion_stiffness[i] = '0;
				matrix_stiffness[i]    = '0;
			end
			component_count = 3'd6;
			expected_stress_q.delete();
			mismatch_count  = 0;
			results_checked = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.y   = m_tdata;
				got.sat = m_tuser;
				if (expected_stress_q.size() == 0) begin
					report_mismatch("result beat arrived with no result expected");
				end else begin
					want = expected_stress_q[0];
					expected_stress_q.delete(0);
					results_checked++;
					for (int k = 0; k < NUM_X; k++) begin
						if (got.y[k] !== want.y[k]) begin
							report_mismatch($sformatf("y_%0d is %h, expected %h",
								k, got.y[k], want.y[k]));
						end
					end
					if (got.sat !== want.sat) begin
						report_mismatch($sformatf("saturated is %b, expected %b",
							got.sat, want.sat));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				row    = s_tdata[ROW_LSB +: IDX_W];
				col    = s_tdata[COL_LSB +: IDX_W];
				coef   = s_tdata[COEF_LSB +: DATA_W];
				strain = s_tdata[X_LSB +: NUM_X*DATA_W];
				if (s_tuser[0] == OP_APPLY) begin
					expected_stress_q.insert(expected_stress_q.size(),
						compute_stress(s_tuser[1], strain));
				end else if (row < MAX_COMPONENTS && col < MAX_COMPONENTS) begin
					if (s_tuser[1] == PHASE_INCLUSION) begin
						inclusion_stiffness[row*MAX_COMPONENTS+col] = coef;
					end else begin
						matrix_stiffness[row*MAX_COMPONENTS+col] = coef;
					end
				end
			end
			if (cfg_wr_en) begin
				component_count = cfg_wr_data;
			end
			outstanding <= expected_stress_q.size();
		end
	end

endmodule

>>> dv/tb_two_phase_stiffness_matvec_top.sv
// ----------------------------------------------------------------------------
// tb_two_phase_stiffness_matvec_top: testbench for the stiffness mat-vec unit
// Loads extreme and random coefficients into both matrices, applies extreme
// and random strain vectors under component counts from zero to seven, and
// lets the checker compare every result. Both stream sides idle at random,
// the receiver once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_phase_stiffness_matvec_top;
	import tpsm_pkg::*;

	localparam int MAX_COMPONENTS = 6;
	localparam int FRAC_BITS      = 16;
	localparam int SETTLE_CYCLES  = 2 * MAX_COMPONENTS + 8;
	localparam int STALL_LIMIT    = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_ITEMS   = 1530;
	localparam int NUM_SETTINGS   = 9;
	localparam int HOLD_SETTING   = 7;

	localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [IDX_W-1:0]      cfg_wr_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	int mismatch_count;
	int outstanding;
	int results_checked;
	int tx_idle_pct;
	int rx_idle_pct;
	int holds_asked;
	int loads_sent;
	int applies_sent;
	int stall_cycles = 0;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	two_phase_stiffness_matvec_top #(
		.MAX_COMPONENTS(MAX_COMPONENTS),
		.FRAC_BITS     (FRAC_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	two_phase_stiffness_matvec_checker #(
		.MAX_COMPONENTS(MAX_COMPONENTS),
		.FRAC_BITS     (FRAC_BITS)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding),
		.results_checked(results_checked)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
				$display("two_phase_stiffness_matvec_top test failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int holds_done;
		holds_done = 0;
		m_tready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic logic [DATA_W-1:0] rand_word();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3, 4, 5: return $urandom;
			default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	function automatic logic [NUM_X-1:0][DATA_W-1:0] rand_strain();
		logic [NUM_X-1:0][DATA_W-1:0] v;
		for (int l = 0; l < NUM_X; l++) begin
			v[l] = rand_word();
		end
		return v;
	endfunction

	function automatic logic [IDX_W-1:0] rand_index();
		if ($urandom_range(9) == 0) begin
			return IDX_W'($urandom_range(7, MAX_COMPONENTS));
		end
		return IDX_W'($urandom_range(MAX_COMPONENTS - 1));
	endfunction

	task automatic offer(input logic op, input logic phase, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] coef,
			input logic [NUM_X-1:0][DATA_W-1:0] strain);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {phase, op};
		s_tdata  <= {2'b00, strain, coef, col, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_APPLY) begin
			applies_sent++;
		end else begin
			loads_sent++;
		end
	endtask

	task automatic load_coef(input logic phase, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] coef);
		offer(OP_LOAD, phase, row, col, coef, rand_strain());
	endtask

	task automatic apply_strain(input logic phase, input logic [NUM_X-1:0][DATA_W-1:0] strain);
		offer(OP_APPLY, phase, IDX_W'($urandom), IDX_W'($urandom), $urandom, strain);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(input logic [IDX_W-1:0] count);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= count;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		int count_plan [NUM_SETTINGS];
		int per_setting;
		int sent;
		count_plan   = '{1, 6, 3, 7, 2, 5, 0, 4, 6};
		per_setting  = RANDOM_ITEMS / NUM_SETTINGS;
		sent         = 0;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		tx_idle_pct  = 19;
		rx_idle_pct  = 78;
		holds_asked  = 0;
		loads_sent   = 0;
		applies_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_count(3'd6);
		load_coef(PHASE_INCLUSION, 3'd0, 3'd0, Q_MAX);
		load_coef(PHASE_INCLUSION, 3'd0, 3'd1, Q_MIN);
		load_coef(PHASE_INCLUSION, 3'd1, 3'd0, Q_MIN);
		load_coef(PHASE_INCLUSION, 3'd1, 3'd1, Q_MIN);
		load_coef(PHASE_MATRIX, 3'd0, 3'd0, Q_ONE);
		load_coef(PHASE_MATRIX, 3'd5, 3'd5, Q_MIN);
		load_coef(PHASE_MATRIX, 3'd6, 3'd0, 32'hDEAD_BEEF);
		load_coef(PHASE_INCLUSION, 3'd2, 3'd7, 32'h1234_5678);
		load_coef(PHASE_MATRIX, 3'd7, 3'd7, Q_MAX);
		apply_strain(PHASE_INCLUSION, {NUM_X{Q_MAX}});
		apply_strain(PHASE_INCLUSION, {NUM_X{Q_MIN}});
		apply_strain(PHASE_INCLUSION, {{4{32'hFFFF_FFFF}}, Q_MIN, Q_MAX});
		apply_strain(PHASE_MATRIX, {NUM_X{Q_MIN}});
		apply_strain(PHASE_MATRIX, '0);
		apply_strain(PHASE_MATRIX, rand_strain());
		drain();
		set_count(3'd0);
		apply_strain(PHASE_INCLUSION, {NUM_X{Q_MAX}});
		apply_strain(PHASE_MATRIX, rand_strain());
		drain();
		set_count(3'd7);
		apply_strain(PHASE_INCLUSION, {NUM_X{Q_MIN}});
		apply_strain(PHASE_MATRIX, rand_strain());
		drain();

		for (int p = 0; p < NUM_SETTINGS; p++) begin
			set_count(IDX_W'(count_plan[p]));
			if (p == HOLD_SETTING) begin
				holds_asked++;
			end
			for (int i = 0; i < per_setting; i++) begin
				if (sent < RANDOM_ITEMS / 3) begin
					tx_idle_pct = 19;
					rx_idle_pct = 78;
				end else if (sent < 2 * RANDOM_ITEMS / 3) begin
					tx_idle_pct = 78;
					rx_idle_pct = 19;
				end else begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				if ($urandom_range(9) < 3) begin
					load_coef(1'($urandom), rand_index(), rand_index(), rand_word());
				end else begin
					apply_strain(1'($urandom), rand_strain());
				end
				sent++;
			end
			drain();
		end

		$display("Covered %0d load beats and %0d apply beats on both matrices,",
			loads_sent, applies_sent);
		$display("component counts 0 to 7, %0d results compared.", results_checked);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("two_phase_stiffness_matvec_top test passed");
		end else begin
			$display("two_phase_stiffness_matvec_top test failed");
		end
		$finish;
	end

endmodule
